// ===== sv/rbsf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the radial blur / sharpen filter
// no dependencies

package rbsf_pkg;

    // line store geometry
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int EH_W       = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W     = EW_W;

    // radial distance arithmetic
    localparam int RAD_W  = (COL_W > 8) ? COL_W : 8;
    localparam int MAXC_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int D2_W   = 2 * ((MAXC_W > RAD_W) ? MAXC_W : RAD_W) + 1;

    // neighbour sums: up to four neighbours, plus the center
    localparam int NB_W  = 10;
    localparam int SUM_W = 11;

    // reciprocal constants for floor division by 3 and by 5
    localparam int          RECIP_W  = 17;
    localparam logic [16:0] RECIP3   = 17'd43691;
    localparam logic [16:0] RECIP5   = 17'd52429;
    localparam int          SHIFT3   = 17;
    localparam int          SHIFT5   = 18;
    localparam int          PROD_W   = SUM_W + RECIP_W;

    // configuration port
    localparam int              CFG_INDEX_W        = 2;
    localparam int              CFG_DATA_W         = 13;
    localparam logic [1:0]      CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0]      CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0]      CFG_RING_THICKNESS = 2'd2;
    localparam logic [11:0]     IMAGE_WIDTH_RESET  = 12'd480;
    localparam logic [12:0]     IMAGE_HEIGHT_RESET = 13'd640;
    localparam logic [7:0]      RING_RESET         = 8'd5;

    // item operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // ring color
    localparam logic [23:0] RING_COLOR = 24'hff0000;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } result_item_t;

    // floor(total / (nbr + 1)) for nbr in 0..4
    function automatic logic [7:0] blur_div(input logic [SUM_W-1:0] total,
                                            input logic [2:0]       nbr);
        logic [PROD_W-1:0] prod;
        logic [SUM_W-1:0]  quo;
        prod = PROD_W'(total) * PROD_W'((nbr == 3'd2) ? RECIP3 : RECIP5);
        case (nbr)
            3'd1:    quo = total >> 1;
            3'd2:    quo = SUM_W'(prod >> SHIFT3);
            3'd3:    quo = total >> 2;
            3'd4:    quo = SUM_W'(prod >> SHIFT5);
            default: quo = total;
        endcase
        return quo[7:0];
    endfunction

    // (nbr + 1) * center - neighbours, clamped to 0..255
    function automatic logic [7:0] sharpen(input logic [7:0]      center,
                                           input logic [NB_W-1:0] nb,
                                           input logic [2:0]      nbr);
        logic [SUM_W-1:0]        scaled;
        logic signed [SUM_W:0]   diff;
        logic [7:0]              res;
        scaled = SUM_W'(center) * (SUM_W'(nbr) + SUM_W'(1));
        diff   = $signed({1'b0, scaled}) - $signed((SUM_W + 1)'(nb));
        if (diff < 0)
        begin
            res = 8'd0;
        end
        else if (diff > $signed((SUM_W + 1)'(255)))
        begin
            res = 8'd255;
        end
        else
        begin
            res = diff[7:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/radial_blur_sharpen_filter_top.sv =====
`timescale 1ns / 1ps
// radial blur / sharpen filter over an RGB raster with two line stores
// depends on rbsf_pkg
//
// path: a result item passes the read, side, calc and send states after the pixel or flush
//   item that causes it, waiting in send while the output register is stalled; an item is
//   taken only in idle: one yielding a result holds the input through read, side, calc and
//   send (longer while the output is stalled), a first-row pixel through read only, while a
//   flush with nothing pending never leaves idle; set by two dependent read rounds on the
//   line stores (center/up, then right/left) and the arithmetic stages behind them
// reset: counters and output valid clear, config registers take reset values at once; the
//   line stores are not cleared and need no sweep, so items are taken right after reset

module radial_blur_sharpen_filter_top
    import rbsf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  pixel_item_t            pixel_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_item_t           result_item
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // take an item, read center and up
    localparam logic [2:0] ST_READ = 3'd1;  // shift the column, read right and left
    localparam logic [2:0] ST_SIDE = 3'd2;  // neighbour sums and squares
    localparam logic [2:0] ST_CALC = 3'd3;  // region compares, blur and sharpen values
    localparam logic [2:0] ST_SEND = 3'd4;  // load the output register when it is free

    // configuration registers
    logic [11:0]           width_reg;
    logic [12:0]           height_reg;
    logic [7:0]            ring_reg;

    // frame counters
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [2:0]            state_reg, state_next;

    // effective geometry
    logic [EW_W-1:0]       eff_w;
    logic [EH_W-1:0]       eff_h;
    logic [COL_W-1:0]      half_w;
    logic [ROW_W-1:0]      half_h;

    // accept-time decode
    logic                  pixel_accept;
    logic [COL_W-1:0]      x_acc;
    logic [ROW_W-1:0]      y_acc;
    logic [ROW_W-1:0]      geo_y_acc;
    logic                  work_acc, emit_acc, last_acc, down_acc;

    // per-item registers
    logic [COL_W-1:0]      x_reg;
    logic [ROW_W-1:0]      geo_y_reg;
    logic                  is_pixel_reg, emit_reg, last_reg;
    logic                  has_up_reg, has_left_reg, has_down_reg, has_right_reg;
    logic [23:0]           pix_reg;
    logic [23:0]           center_reg, up_reg;

    // line stores: above holds the older row, mid the newer one
    logic [23:0]           above_mem [MAX_WIDTH];
    logic [23:0]           mid_mem   [MAX_WIDTH];
    logic [23:0]           above_q, mid_q;
    logic                  mem_re;
    logic [COL_W-1:0]      above_raddr, mid_raddr;
    logic                  above_we, mid_we;

    // distance pipeline
    logic [COL_W-1:0]      adx_reg, ar_reg;
    logic [ROW_W-1:0]      ady_reg;
    logic [RAD_W-1:0]      ari_reg;
    logic [D2_W-1:0]       dx2_reg, dy2_reg, r2_reg, ri2_reg;
    logic [D2_W-1:0]       d2;
    logic                  blur_flag_reg, ring_flag_reg;

    // channel pipeline, channel 0 is red
    logic [NB_W-1:0]       nb_reg    [3];
    logic [NB_W-1:0]       nb_next   [3];
    logic [2:0]            n_reg;
    logic [7:0]            blur_reg  [3];
    logic [7:0]            sharp_reg [3];

    // output register
    logic                  result_valid_reg;
    result_item_t          result_item_reg, result_item_next;
    logic                  send_ok;
    logic [23:0]           send_pix;

    assign cfg_ready    = 1'b1;
    assign pixel_stall  = (state_reg != ST_IDLE);
    assign pixel_accept = pixel_valid && !pixel_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;
    assign send_ok      = !result_valid_reg || !result_stall;

    // width or height 0 acts as 1; past MAX_WIDTH or MAX_HEIGHT it acts as that maximum
    always_comb
    begin
        if (width_reg == 12'd0)
        begin
            eff_w = EW_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(width_reg);
        end

        if (height_reg == 13'd0)
        begin
            eff_h = EH_W'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_h = EH_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = EH_W'(height_reg);
        end

        half_w = COL_W'(eff_w >> 1);
        half_h = ROW_W'(eff_h >> 1);
    end

    // item decode and counter update at the accept edge
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        x_acc     = col_reg;
        y_acc     = row_reg;
        geo_y_acc = '0;
        work_acc  = 1'b0;
        emit_acc  = 1'b0;
        last_acc  = 1'b0;
        down_acc  = 1'b0;

        if (pixel_item.operation == OP_PIXEL)
        begin
            work_acc = 1'b1;
            // a pixel while a row is still pending drops it and opens a new frame
            if (pend_reg != '0)
            begin
                x_acc     = '0;
                y_acc     = '0;
                pend_next = '0;
            end
            emit_acc  = (y_acc != '0);
            geo_y_acc = y_acc - ROW_W'(1);
            down_acc  = (EH_W'(y_acc) < eff_h);
            if (EW_W'(x_acc) >= eff_w - EW_W'(1))
            begin
                col_next = '0;
                if (EH_W'(y_acc) >= eff_h - EH_W'(1))
                begin
                    // frame done: the last row waits for flush items
                    row_next  = '0;
                    pend_next = PEND_W'(EW_W'(x_acc) + EW_W'(1));
                end
                else
                begin
                    row_next = y_acc + ROW_W'(1);
                end
            end
            else
            begin
                col_next = x_acc + COL_W'(1);
            end
        end
        else if (pend_reg != '0)
        begin
            // flush: emit the next pixel of the last row, no down neighbour
            work_acc  = 1'b1;
            emit_acc  = 1'b1;
            geo_y_acc = ROW_W'(eff_h - EH_W'(1));
            pend_next = pend_reg - PEND_W'(1);
            if (pend_next == '0)
            begin
                last_acc = 1'b1;
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end

        if (!pixel_accept)
        begin
            col_next  = col_reg;
            row_next  = row_reg;
            pend_next = pend_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pixel_accept && work_acc)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = emit_reg ? ST_SIDE : ST_IDLE;
            end
            ST_SIDE:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (send_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= IMAGE_WIDTH_RESET;
            height_reg       <= IMAGE_HEIGHT_RESET;
            ring_reg         <= RING_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg  <= cfg_data[11:0];
                    CFG_IMAGE_HEIGHT:   height_reg <= cfg_data[12:0];
                    CFG_RING_THICKNESS: ring_reg   <= cfg_data[7:0];
                    default:            ;
                endcase
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            state_reg <= state_next;
            if (state_reg == ST_SEND && send_ok)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // line store ports: first round reads column x, second round x+1 and x-1
    // while column x shifts down; the reads of the second round never touch column x
    always_comb
    begin
        mem_re      = 1'b0;
        mid_raddr   = x_acc;
        above_raddr = x_acc;
        if (state_reg == ST_IDLE)
        begin
            mem_re = pixel_accept;
        end
        else if (state_reg == ST_READ)
        begin
            mem_re      = 1'b1;
            mid_raddr   = x_reg + COL_W'(1);
            above_raddr = x_reg - COL_W'(1);
        end
    end

    assign above_we = (state_reg == ST_READ);
    assign mid_we   = (state_reg == ST_READ) && is_pixel_reg;

    always_ff @(posedge clk)
    begin
        if (above_we)
        begin
            above_mem[x_reg] <= mid_q;
        end
        if (mem_re)
        begin
            above_q <= above_mem[above_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
        begin
            mid_mem[x_reg] <= pix_reg;
        end
        if (mem_re)
        begin
            mid_q <= mid_mem[mid_raddr];
        end
    end

    // neighbour sums of the plus-shaped window
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nb_next[k] = (has_up_reg    ? NB_W'(up_reg [8*(2-k) +: 8])  : '0)
                       + (has_left_reg  ? NB_W'(above_q[8*(2-k) +: 8]) : '0)
                       + (has_down_reg  ? NB_W'(pix_reg[8*(2-k) +: 8]) : '0)
                       + (has_right_reg ? NB_W'(mid_q  [8*(2-k) +: 8]) : '0);
        end
    end

    assign d2 = dx2_reg + dy2_reg;

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pixel_accept)
        begin
            x_reg         <= x_acc;
            geo_y_reg     <= geo_y_acc;
            is_pixel_reg  <= (pixel_item.operation == OP_PIXEL);
            emit_reg      <= emit_acc;
            last_reg      <= last_acc;
            has_up_reg    <= (geo_y_acc != '0);
            has_left_reg  <= (x_acc != '0);
            has_down_reg  <= down_acc;
            has_right_reg <= (EW_W'(x_acc) + EW_W'(1) < eff_w);
            pix_reg       <= {pixel_item.red, pixel_item.green, pixel_item.blue};
        end

        if (state_reg == ST_READ)
        begin
            center_reg <= mid_q;
            up_reg     <= above_q;
            adx_reg    <= (x_reg >= half_w) ? x_reg - half_w : half_w - x_reg;
            ady_reg    <= (geo_y_reg >= half_h) ? geo_y_reg - half_h : half_h - geo_y_reg;
            ar_reg     <= half_w;
            // inner radius may go negative; only its magnitude matters once squared
            ari_reg    <= (RAD_W'(half_w) >= RAD_W'(ring_reg))
                          ? RAD_W'(half_w) - RAD_W'(ring_reg)
                          : RAD_W'(ring_reg) - RAD_W'(half_w);
        end

        if (state_reg == ST_SIDE)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nb_reg[k] <= nb_next[k];
            end
            n_reg   <= 3'(has_up_reg) + 3'(has_left_reg) + 3'(has_down_reg)
                     + 3'(has_right_reg);
            dx2_reg <= D2_W'({{COL_W{1'b0}}, adx_reg} * {{COL_W{1'b0}}, adx_reg});
            dy2_reg <= D2_W'({{ROW_W{1'b0}}, ady_reg} * {{ROW_W{1'b0}}, ady_reg});
            r2_reg  <= D2_W'({{COL_W{1'b0}}, ar_reg} * {{COL_W{1'b0}}, ar_reg});
            ri2_reg <= D2_W'({{RAD_W{1'b0}}, ari_reg} * {{RAD_W{1'b0}}, ari_reg});
        end

        if (state_reg == ST_CALC)
        begin
            blur_flag_reg <= (d2 > r2_reg);
            ring_flag_reg <= (d2 > ri2_reg);
            for (int k = 0; k < 3; k++)
            begin
                blur_reg[k]  <= blur_div(SUM_W'(nb_reg[k]) + SUM_W'(center_reg[8*(2-k) +: 8]),
                                         n_reg);
                sharp_reg[k] <= sharpen(center_reg[8*(2-k) +: 8], nb_reg[k], n_reg);
            end
        end

        if (state_reg == ST_SEND && send_ok)
        begin
            result_item_reg <= result_item_next;
        end
    end

    // outside the circle blur, inside the ring red, interior sharpened
    always_comb
    begin
        if (blur_flag_reg)
        begin
            send_pix = {blur_reg[0], blur_reg[1], blur_reg[2]};
        end
        else if (ring_flag_reg)
        begin
            send_pix = RING_COLOR;
        end
        else
        begin
            send_pix = {sharp_reg[0], sharp_reg[1], sharp_reg[2]};
        end
        result_item_next.out_red   = send_pix[23:16];
        result_item_next.out_green = send_pix[15:8];
        result_item_next.out_blue  = send_pix[7:0];
        result_item_next.frame_end = last_reg;
    end

endmodule
